[hdl/glu_bg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_bg_pkg
// Shared constants, the sigmoid table type and the elaboration-time table
// builder for the gated linear unit backward datapath.
// ----------------------------------------------------------------------------
package glu_bg_pkg;

    // Sigmoid samples are unsigned Q0.16; 1.0 itself needs a 17th bit
    localparam int SIG_W          = 17;
    localparam int INTERP_BITS    = 8;
    localparam int TAYLOR_TERMS   = 24;
    localparam int SIG_DEPTH_MAX  = 4096;
    // Register stages from start to the result strobe
    localparam int LATENCY        = 11;

    localparam logic [SIG_W-1:0] S_ONE   = 17'h1_0000;
    localparam logic [63:0]      ONE_Q32 = 64'h1_0000_0000;

    typedef logic [SIG_W-1:0] t_sig_rom [0:SIG_DEPTH_MAX];
    typedef logic [63:0]      t_pow_tab [0:SIG_DEPTH_MAX];

    // Restoring long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid points over [-8, 8], depth+1 entries, unsigned Q0.16
    function automatic t_sig_rom build_sig_rom(input int depth);
        t_sig_rom     rom;
        t_pow_tab     pw;
        logic [63:0]  h;
        logic [63:0]  term;
        logic [63:0]  e;
        logic [63:0]  p;
        logic [63:0]  den;
        logic [63:0]  num;
        logic [127:0] prod;
        int           d;
        int           j;
        rom  = '{default: '0};
        pw   = '{default: '0};
        h    = udiv64(64'd8 << 32, 64'(depth));
        term = ONE_Q32;
        e    = ONE_Q32;
        // exp(-8/depth) by a truncated Taylor series
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            prod = 128'(term) * 128'(h);
            term = udiv64(prod[95:32], 64'(n));
            if (n % 2 == 1) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        pw[0] = ONE_Q32;
        for (int k = 1; k <= depth; k++) begin
            prod  = 128'(pw[k-1]) * 128'(e) + 128'(64'h8000_0000);
            pw[k] = prod[95:32];
        end
        for (int k = 0; k <= depth; k++) begin
            d   = 2 * k - depth;
            j   = (d < 0) ? -d : d;
            p   = pw[j];
            den = ONE_Q32 + p;
            num = (d >= 0) ? (64'd1 << 48) : (p << 16);
            rom[k] = SIG_W'(udiv64(num + (den >> 1), den));
        end
        return rom;
    endfunction

endpackage

[hdl/glu_backward_gradient.sv]
// Every accepted start yields one o_valid strobe at the end of the pipeline.
// Throughput: one item per cycle; busy stays low, start may be held high.
// The sigmoid ROM read (two registered ports) and the four multiply stages
// (g*s and s*(1-s) share one) each own a stage; rounding follows each product.
// Reset (i_rst_n low, synchronous) drops every item in flight; no strobe
// follows for items accepted before it. The receiver cannot stall.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_backward_gradient
// Gated linear unit backward pass: da = g*s, db = g*a*s*(1-s), s = sigmoid(b),
// with s from an interpolated table, rounding to nearest and saturation.
// ----------------------------------------------------------------------------
module glu_backward_gradient #(
    parameter int DATA_WIDTH      = 16,
    parameter int FRAC_BITS       = 12,
    parameter int SIG_TABLE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_lin_value,
    input  logic signed [DATA_WIDTH-1:0] i_gate_value,
    input  logic signed [DATA_WIDTH-1:0] i_upstream_grad,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_grad_lin,
    output logic signed [DATA_WIDTH-1:0] o_grad_gate
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = glu_bg_pkg::SIG_W;
    localparam int IB   = glu_bg_pkg::INTERP_BITS;
    localparam int LAT  = glu_bg_pkg::LATENCY;
    // Clamp arithmetic must hold both the input and +/-8.0
    localparam int BW   = ((DW > FRAC_BITS + 4) ? DW : FRAC_BITS + 4) + 2;
    // Offset gate value spans [0, 16.0)
    localparam int UW   = FRAC_BITS + 4;
    localparam int IW   = $clog2(SIG_TABLE_DEPTH + 1);
    localparam int QW   = UW + IW;
    localparam int IPW  = SW + IB;
    localparam int GSW  = DW + SW + 1;
    localparam int SSW  = 2 * SW;
    localparam int DSW  = 15;
    localparam int ADW  = DW + DSW + 1;
    localparam int GTW  = 2 * DW;

    localparam logic signed [BW-1:0] CLAMP_HI =
        BW'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
    localparam logic signed [BW-1:0] CLAMP_LO = -CLAMP_HI - BW'(1);
    localparam logic signed [DW-1:0] SAT_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QW-1:0]        DEPTH_Q  = QW'(SIG_TABLE_DEPTH);
    localparam logic [IW-1:0]        IDX_LAST = IW'(SIG_TABLE_DEPTH - 1);

    localparam glu_bg_pkg::t_sig_rom SIG_ROM =
        glu_bg_pkg::build_sig_rom(SIG_TABLE_DEPTH);

    // Valid bit per stage; bit k belongs to the stage-(k+1) registers
    logic [LAT-1:0] r_vld;

    // Stage 1: captured item
    logic signed [DW-1:0] r1_a, r1_b, r1_g;
    // Stage 2: table address and interpolation weight
    logic [IW-1:0]        r2_idx;
    logic [IB-1:0]        r2_fr;
    logic signed [DW-1:0] r2_a, r2_g;
    // Stage 3: neighboring table points
    logic [SW-1:0]        r3_t0, r3_t1;
    logic [IB-1:0]        r3_fr;
    logic signed [DW-1:0] r3_a, r3_g;
    // Stage 4: interpolation product
    logic [IPW-1:0]       r4_ip;
    logic [SW-1:0]        r4_t0;
    logic signed [DW-1:0] r4_a, r4_g;
    // Stage 5: sigmoid
    logic [SW-1:0]        r5_s;
    logic signed [DW-1:0] r5_a, r5_g;
    // Stage 6: g*s and s*(1-s)
    logic signed [GSW-1:0] r6_gs;
    logic [SSW-1:0]        r6_ss;
    logic signed [DW-1:0]  r6_a, r6_g;
    // Stage 7: da done, sigmoid slope
    logic signed [DW-1:0] r7_da;
    logic [DSW-1:0]       r7_ds;
    logic signed [DW-1:0] r7_a, r7_g;
    // Stage 8: a times slope
    logic signed [ADW-1:0] r8_ads;
    logic signed [DW-1:0]  r8_da, r8_g;
    // Stage 9: t
    logic signed [DW-1:0] r9_t;
    logic signed [DW-1:0] r9_da, r9_g;
    // Stage 10: g*t
    logic signed [GTW-1:0] r10_gt;
    logic signed [DW-1:0]  r10_da;
    // Stage 11: result
    logic signed [DW-1:0] r_grad_lin, r_grad_gate;

    logic signed [BW-1:0]  n_bclamp;
    logic [UW-1:0]         n_u;
    logic [QW-1:0]         n_q;
    logic [QW-1:0]         n_idx_full;
    logic [IW-1:0]         n_idx;
    logic [IB-1:0]         n_fr;
    logic [SW-1:0]         n_diff;
    logic [IPW:0]          n_ip_sum;
    logic [SW-1:0]         n_s;
    logic signed [GSW:0]   n_gs_sum;
    logic signed [GSW:0]   n_gs_shift;
    logic signed [DW-1:0]  n_da;
    logic [SSW:0]          n_ss_sum;
    logic [DSW-1:0]        n_ds;
    logic signed [ADW:0]   n_ads_sum;
    logic signed [ADW:0]   n_ads_shift;
    logic signed [GTW:0]   n_gt_sum;
    logic signed [GTW:0]   n_gt_shift;
    logic signed [DW-1:0]  n_db;

    // Items are never held off
    assign busy = 1'b0;

    // Stage 2: clamp b to [-8, 8) and scale it onto the table grid
    always_comb begin
        if (BW'(r1_b) > CLAMP_HI) begin
            n_bclamp = CLAMP_HI;
        end else if (BW'(r1_b) < CLAMP_LO) begin
            n_bclamp = CLAMP_LO;
        end else begin
            n_bclamp = BW'(r1_b);
        end
        n_u        = UW'(n_bclamp - CLAMP_LO);
        // q = u * depth * 2^8 / 2^(F+4)
        n_q        = (QW'(n_u) * DEPTH_Q) >> (FRAC_BITS - 4);
        n_idx_full = n_q >> IB;
        n_fr       = n_q[IB-1:0];
        n_idx      = (n_idx_full >= DEPTH_Q) ? IDX_LAST : n_idx_full[IW-1:0];
    end

    // Stages 4 and 5: linear interpolation between neighbors
    always_comb begin
        n_diff   = (r3_t1 >= r3_t0) ? (r3_t1 - r3_t0) : '0;
        n_ip_sum = (IPW+1)'(r4_ip) + (IPW+1)'(1 << (IB - 1));
        n_s      = r4_t0 + SW'(n_ip_sum >> IB);
    end

    // Stage 7: round and saturate da, round the slope
    always_comb begin
        n_gs_sum   = (GSW+1)'(r6_gs) + (GSW+1)'(32768);
        n_gs_shift = n_gs_sum >>> 16;
        if (n_gs_shift > (GSW+1)'(SAT_MAX)) begin
            n_da = SAT_MAX;
        end else if (n_gs_shift < (GSW+1)'(SAT_MIN)) begin
            n_da = SAT_MIN;
        end else begin
            n_da = n_gs_shift[DW-1:0];
        end
        n_ss_sum = (SSW+1)'(r6_ss) + (SSW+1)'(32768);
        n_ds     = n_ss_sum[16 +: DSW];
    end

    // Stage 9: t = round(a*ds / 2^16), small enough for DW bits
    always_comb begin
        n_ads_sum   = (ADW+1)'(r8_ads) + (ADW+1)'(32768);
        n_ads_shift = n_ads_sum >>> 16;
    end

    // Stage 11: round g*t back to Q.F and saturate
    always_comb begin
        n_gt_sum   = (GTW+1)'(r10_gt) + (GTW+1)'(64'sd1 <<< (FRAC_BITS - 1));
        n_gt_shift = n_gt_sum >>> FRAC_BITS;
        if (n_gt_shift > (GTW+1)'(SAT_MAX)) begin
            n_db = SAT_MAX;
        end else if (n_gt_shift < (GTW+1)'(SAT_MIN)) begin
            n_db = SAT_MIN;
        end else begin
            n_db = n_gt_shift[DW-1:0];
        end
    end

    // Valid chain: advance every cycle, drop everything on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // Payload pipeline, no reset needed
    always_ff @(posedge i_clk) begin
        r1_a   <= i_lin_value;
        r1_b   <= i_gate_value;
        r1_g   <= i_upstream_grad;

        r2_idx <= n_idx;
        r2_fr  <= n_fr;
        r2_a   <= r1_a;
        r2_g   <= r1_g;

        r3_t0  <= SIG_ROM[r2_idx];
        r3_t1  <= SIG_ROM[r2_idx + IW'(1)];
        r3_fr  <= r2_fr;
        r3_a   <= r2_a;
        r3_g   <= r2_g;

        r4_ip  <= IPW'(n_diff) * IPW'(r3_fr);
        r4_t0  <= r3_t0;
        r4_a   <= r3_a;
        r4_g   <= r3_g;

        r5_s   <= n_s;
        r5_a   <= r4_a;
        r5_g   <= r4_g;

        r6_gs  <= GSW'(r5_g) * $signed({1'b0, r5_s});
        r6_ss  <= SSW'(r5_s) * SSW'(glu_bg_pkg::S_ONE - r5_s);
        r6_a   <= r5_a;
        r6_g   <= r5_g;

        r7_da  <= n_da;
        r7_ds  <= n_ds;
        r7_a   <= r6_a;
        r7_g   <= r6_g;

        r8_ads <= ADW'(r7_a) * $signed({1'b0, r7_ds});
        r8_da  <= r7_da;
        r8_g   <= r7_g;

        r9_t   <= n_ads_shift[DW-1:0];
        r9_da  <= r8_da;
        r9_g   <= r8_g;

        r10_gt <= GTW'(r9_g) * GTW'(r9_t);
        r10_da <= r9_da;

        r_grad_lin  <= r10_da;
        r_grad_gate <= n_db;
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_grad_lin  = r_grad_lin;
    assign o_grad_gate = r_grad_gate;

endmodule

[hdl/glu_bg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_bg_checker
// Port-level checks for the GLU backward block: busy never raised, fixed latency,
// no stray strobes, zero results for a zero upstream gradient and the sign of grad_lin.
// ----------------------------------------------------------------------------
module glu_bg_port_checks #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [DATA_WIDTH-1:0] i_upstream_grad,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_grad_lin,
    input logic signed [DATA_WIDTH-1:0] o_grad_gate
);

    localparam int LAT = glu_bg_pkg::LATENCY;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result strobe missing at fixed latency");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_valid)
        else $error("result strobe without an accepted item");

    a_zero_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_upstream_grad == '0)
            |-> ##LAT (o_grad_lin == '0 && o_grad_gate == '0))
        else $error("zero upstream gradient gave nonzero result");

    a_lin_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_upstream_grad[DATA_WIDTH-1])
            |-> ##LAT !o_grad_lin[DATA_WIDTH-1])
        else $error("grad_lin sign differs from upstream gradient");

endmodule

bind glu_backward_gradient glu_bg_port_checks #(
    .DATA_WIDTH (DATA_WIDTH)
) u_glu_bg_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_upstream_grad (i_upstream_grad),
    .o_valid         (o_valid),
    .o_grad_lin      (o_grad_lin),
    .o_grad_gate     (o_grad_gate)
);
